FILE: hdl/tts_pkg.sv
// Package for the task table scheduler: request/result structs, state codes, op codes.
// No dependencies.
package tts_pkg;
    localparam int NUM_SLOTS = 64;

    typedef enum logic [2:0] {
        ST_FREE     = 3'd0,
        ST_READY    = 3'd1,
        ST_RUNNING  = 3'd2,
        ST_BLOCKED  = 3'd3,
        ST_WAITING  = 3'd4,
        ST_SLEEPING = 3'd5
    } t_slot_state;

    localparam logic [2:0] OP_CREATE   = 3'd0;
    localparam logic [2:0] OP_BLOCK    = 3'd1;
    localparam logic [2:0] OP_UNBLOCK  = 3'd2;
    localparam logic [2:0] OP_SLEEP    = 3'd3;
    localparam logic [2:0] OP_TICK     = 3'd4;
    localparam logic [2:0] OP_SCHEDULE = 3'd5;

    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_FULL = 2'd1;
    localparam logic [1:0] STS_BAD  = 2'd2;

    localparam logic [0:0] CFG_MS_PER_TICK = 1'd0;
    localparam logic [0:0] CFG_IDLE_SLOT   = 1'd1;

    typedef struct packed {
        logic [2:0]  operation;
        logic [5:0]  task_id;
        logic [7:0]  priority_req;
        logic        block_kind;
        logic [31:0] sleep_ms;
    } t_request;

    typedef struct packed {
        logic [5:0] result_slot;
        logic [5:0] running_slot;
        logic       switched;
        logic [1:0] status;
    } t_result;
endpackage

FILE: hdl/tts_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hdl/tts_div.sv
// Restoring divider, one quotient bit per cycle: 32-bit dividend by 10-bit divisor.
// No dependencies.
module tts_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [9:0]  i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    logic [31:0] r_q;
    logic [9:0]  r_rem;
    logic [9:0]  r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [10:0] w_trial;
    logic [10:0] w_diff;

    assign w_trial = {r_rem, r_q[31]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= (i_divisor == 10'd0) ? 10'd1 : i_divisor;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                if (!w_diff[10]) begin
                    r_rem <= w_diff[9:0];
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= w_trial[9:0];
                    r_q   <= {r_q[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_q;
endmodule

FILE: hdl/task_table_scheduler_core.sv
// Task table scheduler: slot table in RAM walked by a small sequencer, one request at a time.
// Steps, accepting edge to result strobe: schedule is a table sweep, a retire and a commit;
// tick and a full create are a table sweep, block/unblock a single slot access, block of the running task
// adds a schedule, sleep is a slot read, a divide, then a schedule. Busy stays high until the result.
// Requests are served one at a time through the single table read port and the one comparator in the sweep.
// Reset: synchronous active low; a clearing pass frees all slots with busy high.
module task_table_scheduler_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  tts_pkg::t_request i_request,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [9:0]        i_cfg_data,
    output logic              o_result_valid,
    output tts_pkg::t_result  o_result
);
    import tts_pkg::*;

    localparam int AW = $clog2(NUM_SLOTS);
    localparam int EW = 3 + 8 + 32;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CREATE, S_ACCESS, S_DIV, S_SLEEPWR,
        S_TICK, S_SCAN, S_CURFIX, S_COMMIT, S_DONE
    } t_state;

    t_state       r_state;
    logic [AW:0]  r_idx;          // sweep counter, one extra bit for the end
    logic [AW-1:0] r_waddr;
    logic         r_we;
    logic [EW-1:0] r_wdata;
    logic [AW-1:0] r_raddr;
    logic [EW-1:0] w_rdata;
    logic         r_rd_ok;        // a sweep read was issued at the last edge
    logic [AW-1:0] r_rd_addr;
    logic         r_pipe_ok;      // read data of r_pipe_addr valid this cycle
    logic [AW-1:0] r_pipe_addr;

    t_request     r_req;
    logic [9:0]   r_ms_per_tick;
    logic [5:0]   r_idle_slot;
    logic [31:0]  r_now;
    logic [AW-1:0] r_cur;
    logic         r_cur_valid;
    logic [AW-1:0] r_prev_cur;
    logic         r_prev_valid;
    logic [1:0]   r_status;
    logic         r_created;
    logic [AW-1:0] r_new_slot;
    logic         r_best_ok;
    logic [AW-1:0] r_best;
    logic [31:0]  r_best_ticks;
    logic         r_div_start;
    logic         w_div_done;
    logic [31:0]  w_quot;

    t_slot_state  w_st;
    logic [7:0]   w_pri;
    logic [31:0]  w_tk;
    logic         w_tid_ok;

    assign w_st  = t_slot_state'(w_rdata[EW-1 -: 3]);
    assign w_pri = w_rdata[39:32];
    assign w_tk  = w_rdata[31:0];
    assign w_tid_ok = ({1'b0, i_request.task_id} < 7'(NUM_SLOTS));

    tts_ram #(.WIDTH(EW), .DEPTH(NUM_SLOTS)) u_table (
        .i_clk  (i_clk),
        .i_we   (r_we),
        .i_waddr(r_waddr),
        .i_wdata(r_wdata),
        .i_raddr(r_raddr),
        .o_rdata(w_rdata)
    );

    tts_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_dividend(r_req.sleep_ms),
        .i_divisor (r_ms_per_tick),
        .o_done    (w_div_done),
        .o_quotient(w_quot)
    );

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_idx          <= '0;
            r_we           <= 1'b0;
            r_ms_per_tick  <= 10'd10;
            r_idle_slot    <= 6'd0;
            r_now          <= '0;
            r_cur          <= '0;
            r_cur_valid    <= 1'b0;
            o_result_valid <= 1'b0;
            r_div_start    <= 1'b0;
            r_rd_ok        <= 1'b0;
            r_pipe_ok      <= 1'b0;
        end else begin
            r_we           <= 1'b0;
            o_result_valid <= 1'b0;
            r_div_start    <= 1'b0;
            r_rd_ok        <= 1'b0;
            // the RAM returns data in the cycle after the address: tag it to match
            r_pipe_ok      <= r_rd_ok;
            r_pipe_addr    <= r_rd_addr;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MS_PER_TICK) r_ms_per_tick <= i_cfg_data;
                else r_idle_slot <= i_cfg_data[5:0];
            end
            case (r_state)
                S_CLEAR: begin
                    // free one slot a cycle
                    r_we    <= 1'b1;
                    r_waddr <= r_idx[AW-1:0];
                    r_wdata <= {ST_FREE, 40'd0};
                    r_idx   <= r_idx + 1'b1;
                    if (r_idx == (AW+1)'(NUM_SLOTS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_req        <= i_request;
                        r_prev_cur   <= r_cur;
                        r_prev_valid <= r_cur_valid;
                        r_status     <= STS_OK;
                        r_created    <= 1'b0;
                        r_best_ok    <= 1'b0;
                        r_idx        <= '0;
                        r_rd_ok      <= 1'b0;
                        case (i_request.operation)
                            OP_CREATE: begin
                                r_raddr <= '0; r_rd_addr <= '0; r_rd_ok <= 1'b1;
                                r_idx   <= (AW+1)'(1);
                                r_status <= STS_FULL;
                                r_state <= S_CREATE;
                            end
                            OP_BLOCK, OP_UNBLOCK: begin
                                if (!w_tid_ok) begin
                                    r_status <= STS_BAD;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_raddr <= i_request.task_id[AW-1:0];
                                    r_state <= S_ACCESS;
                                end
                            end
                            OP_SLEEP: begin
                                if (!r_cur_valid) begin
                                    r_status <= STS_BAD;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_raddr <= r_cur;
                                    r_state <= S_ACCESS;
                                end
                            end
                            OP_TICK: begin
                                r_now   <= r_now + 32'd1;
                                r_raddr <= '0; r_rd_addr <= '0; r_rd_ok <= 1'b1;
                                r_idx   <= (AW+1)'(1);
                                r_state <= S_TICK;
                            end
                            OP_SCHEDULE: begin
                                r_raddr <= '0; r_rd_addr <= '0; r_rd_ok <= 1'b1;
                                r_idx   <= (AW+1)'(1);
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_status <= STS_BAD;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_CREATE: begin
                    // first free slot wins; advance reads until found
                    if (r_pipe_ok && w_st == ST_FREE) begin
                        r_we      <= 1'b1;
                        r_waddr   <= r_pipe_addr;
                        r_wdata   <= {ST_READY, r_req.priority_req, 24'd0, r_req.priority_req};
                        r_created <= 1'b1;
                        r_new_slot <= r_pipe_addr;
                        r_status  <= STS_OK;
                        r_state   <= S_DONE;
                    end else if (r_idx == (AW+1)'(NUM_SLOTS)) begin
                        if (!r_rd_ok) r_state <= S_DONE;
                    end else begin
                        r_raddr   <= r_idx[AW-1:0];
                        r_rd_addr <= r_idx[AW-1:0];
                        r_rd_ok   <= 1'b1;
                        r_idx     <= r_idx + 1'b1;
                    end
                end
                S_ACCESS: begin
                    // wait for the registered read of the addressed slot
                    if (r_idx == '0) begin
                        r_idx <= (AW+1)'(1);
                    end else begin
                        r_state <= S_DONE;
                        case (r_req.operation)
                            OP_BLOCK: begin
                                if (w_st != ST_READY && w_st != ST_RUNNING) begin
                                    r_status <= STS_BAD;
                                end else begin
                                    r_we    <= 1'b1;
                                    r_waddr <= r_raddr;
                                    r_wdata <= {(r_req.block_kind ? ST_WAITING : ST_BLOCKED),
                                                w_rdata[39:0]};
                                    if (r_cur_valid && r_cur == r_raddr) begin
                                        r_raddr <= '0; r_rd_addr <= '0; r_rd_ok <= 1'b1;
                                        r_idx   <= (AW+1)'(1);
                                        r_state <= S_SCAN;
                                    end
                                end
                            end
                            OP_UNBLOCK: begin
                                if (w_st != ST_BLOCKED && w_st != ST_WAITING
                                    && w_st != ST_SLEEPING) begin
                                    r_status <= STS_BAD;
                                end else begin
                                    r_we    <= 1'b1;
                                    r_waddr <= r_raddr;
                                    r_wdata <= {ST_READY, w_rdata[39:0]};
                                end
                            end
                            default: begin
                                // sleep: hold the entry, start the divide
                                if (w_st != ST_RUNNING) begin
                                    r_status <= STS_BAD;
                                end else begin
                                    r_wdata     <= w_rdata;
                                    r_div_start <= 1'b1;
                                    r_state     <= S_DIV;
                                end
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_we    <= 1'b1;
                        r_waddr <= r_cur;
                        r_wdata <= {ST_SLEEPING, r_wdata[39:32],
                                    r_now + ((w_quot == 32'd0) ? 32'd1 : w_quot)};
                        r_state <= S_SLEEPWR;
                    end
                end
                S_SLEEPWR: begin
                    r_raddr <= '0; r_rd_addr <= '0; r_rd_ok <= 1'b1;
                    r_idx   <= (AW+1)'(1);
                    r_state <= S_SCAN;
                end
                S_TICK: begin
                    // wake due sleepers
                    if (r_pipe_ok && w_st == ST_SLEEPING && w_tk <= r_now) begin
                        r_we    <= 1'b1;
                        r_waddr <= r_pipe_addr;
                        r_wdata <= {ST_READY, w_pri, 32'd0};
                    end
                    if (r_idx == (AW+1)'(NUM_SLOTS)) begin
                        if (!r_rd_ok) r_state <= S_DONE;
                    end else begin
                        r_raddr   <= r_idx[AW-1:0];
                        r_rd_addr <= r_idx[AW-1:0];
                        r_rd_ok   <= 1'b1;
                        r_idx     <= r_idx + 1'b1;
                    end
                end
                S_SCAN: begin
                    // one compare per slot: keep the ready slot with most ticks
                    if (r_pipe_ok && w_st == ST_READY
                        && !(r_cur_valid && r_pipe_addr == r_cur)
                        && (!r_best_ok || w_tk > r_best_ticks)) begin
                        r_best_ok    <= 1'b1;
                        r_best       <= r_pipe_addr;
                        r_best_ticks <= w_tk;
                    end
                    if (r_idx == (AW+1)'(NUM_SLOTS)) begin
                        if (!r_rd_ok) begin
                            r_raddr <= r_cur;
                            r_state <= S_CURFIX;
                            r_idx   <= '0;
                        end
                    end else begin
                        r_raddr   <= r_idx[AW-1:0];
                        r_rd_addr <= r_idx[AW-1:0];
                        r_rd_ok   <= 1'b1;
                        r_idx     <= r_idx + 1'b1;
                    end
                end
                S_CURFIX: begin
                    // wait for the registered read of the current slot, then retire it
                    if (r_idx == '0) begin
                        r_idx <= (AW+1)'(1);
                    end else begin
                        if (r_cur_valid) begin
                            r_we    <= 1'b1;
                            r_waddr <= r_cur;
                            r_wdata <= {((w_st == ST_RUNNING) ? ST_READY : w_st), w_pri,
                                        ((w_tk == 32'd0) ? {24'd0, w_pri} : w_tk)};
                        end
                        // the idle slot register spans exactly the table
                        r_raddr <= r_best_ok ? r_best : r_idle_slot;
                        r_idx   <= '0;
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    // read of next happens at the same edge as the retire write and returns stale data: forward it
                    if (r_idx == '0) begin
                        r_idx <= (AW+1)'(1);
                    end else begin
                        r_cur <= r_raddr;
                        if (((r_cur_valid && r_cur == r_raddr) ? r_wdata[EW-1 -: 3] : w_st)
                            != ST_FREE) begin
                            r_we        <= 1'b1;
                            r_waddr     <= r_raddr;
                            r_wdata     <= {ST_RUNNING,
                                ((r_cur_valid && r_cur == r_raddr) ? r_wdata[39:0]
                                                                  : w_rdata[39:0])};
                            r_cur_valid <= 1'b1;
                        end else begin
                            r_cur_valid <= 1'b0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    o_result_valid        <= 1'b1;
                    o_result.result_slot  <= 6'(r_created ? r_new_slot : r_cur);
                    o_result.running_slot <= 6'(r_cur);
                    o_result.switched     <= (r_prev_cur != r_cur) || (r_prev_valid != r_cur_valid);
                    o_result.status       <= r_status;
                    r_state               <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
